/* design/dptp_pkg.sv */
// Shared types, widths and helper functions for the tilted-point pipeline.
// Used by the pipeline top level and by its port checker; no dependencies.
package dptp_pkg;

  // Fixed-point format of every coefficient and zone sine.
  localparam int COEF_FRAC_BITS = 14;
  localparam int COEF_W         = 16;
  localparam int SINE_W         = 15;
  localparam int DIST_W         = 16;
  localparam int ZONE_W         = 3;
  localparam int OUT_W          = 18;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indices.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROT_COS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROT_SIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_ROT_COS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_ROT_SIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_SINE_HALF       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_SINE_ONE_HALF   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_SINE_TWO_HALF   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_SINE_THREE_HALF = 3'd7;

  // Reset values of the registers.
  localparam logic [COEF_W-1:0] RST_FIRST_ROT_COS  = 16'd16384;
  localparam logic [COEF_W-1:0] RST_FIRST_ROT_SIN  = 16'd0;
  localparam logic [COEF_W-1:0] RST_SECOND_ROT_COS = 16'd16384;
  localparam logic [COEF_W-1:0] RST_SECOND_ROT_SIN = 16'd0;
  localparam logic [SINE_W-1:0] RST_SINE_HALF       = 15'd918;
  localparam logic [SINE_W-1:0] RST_SINE_ONE_HALF   = 15'd2744;
  localparam logic [SINE_W-1:0] RST_SINE_TWO_HALF   = 15'd4535;
  localparam logic [SINE_W-1:0] RST_SINE_THREE_HALF = 15'd6270;

  // Intermediate widths, all derived from the field widths and fraction bits.
  localparam int SSINE_W = SINE_W + 1;                   // signed zone sine
  localparam int MUL1_W  = DIST_W + 1 + SSINE_W;         // d * sine, full product
  localparam int XS_W    = DIST_W + SINE_W + 1;          // d * sine, exact range
  localparam int P1_W    = COEF_W + XS_W;                // coef * xs or ys
  localparam int CD_W    = COEF_W + DIST_W + 1;          // coef * d
  localparam int ROT1_W  = ((CD_W + COEF_FRAC_BITS > P1_W) ?
                            CD_W + COEF_FRAC_BITS : P1_W) + 1;
  localparam int ZR_W    = ROT1_W - COEF_FRAC_BITS;
  localparam int P2_W    = COEF_W + ZR_W;                // coef * zr
  localparam int ROT2_W  = P2_W + 1;
  localparam int WIDE_W  = ((ROT1_W > ROT2_W) ? ROT1_W : ROT2_W) + 1;

  localparam int PIPE_DEPTH = 5;
  localparam int CNT_W      = 3;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Round half up from 2F fraction bits to an integer, then saturate.
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] half;
    logic signed [WIDE_W-1:0] t;
    half = WIDE_W'(1) <<< (2 * COEF_FRAC_BITS - 1);
    t    = (v + half) >>> (2 * COEF_FRAC_BITS);
    if (t > WIDE_W'(OUT_MAX)) begin
      round_sat = OUT_MAX;
    end else if (t < WIDE_W'(OUT_MIN)) begin
      round_sat = OUT_MIN;
    end else begin
      round_sat = t[OUT_W-1:0];
    end
  endfunction

endpackage

/* design/depth_pixel_to_tilted_point.sv */
// Five-stage pipeline that turns one depth zone into a tilt-corrected point.
// Depends on dptp_pkg for widths, register indices and the output rounding.
//
// Usage:
//   Input channel (in_valid/in_ready) carries zone_col, zone_row and
//   range_mm of one zone; the output channel (out_valid/out_ready) returns
//   out_x, out_y and out_z in millimetres, rounded and saturated to 18 bits.
//   Registers are written through cfg_wr_en/cfg_index/cfg_data; the user
//   must write them only while no zone is in flight, as the block itself
//   does not enforce it; a write takes effect at once. A zone passes
//   through the stage registers v1, v2, v3 and v4 into the output
//   register. One zone is taken every cycle while the receiver keeps up,
//   so throughput is one item per cycle; the widest work in any stage is
//   the 16 by 35 bit products of the second rotation.
//   Every stage carries its own valid bit and moves on when the stage after
//   it is empty or moving, so bubbles are squeezed out and up to five zones
//   are held while out_ready is low; in_ready falls only when all five
//   stages are full.
//   Synchronous reset empties the pipeline and loads the default rotation
//   (identity) and zone sine values.
module depth_pixel_to_tilted_point
  import dptp_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ZONE_W-1:0]            zone_col,
  input  logic [ZONE_W-1:0]            zone_row,
  input  logic [DIST_W-1:0]            range_mm,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_W-1:0]      out_x,
  output logic signed [OUT_W-1:0]      out_y,
  output logic signed [OUT_W-1:0]      out_z
);

  // Configuration registers.
  logic signed [COEF_W-1:0] c1, s1, c2, s2;
  logic [SINE_W-1:0]        sine_tab [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      c1          <= RST_FIRST_ROT_COS;
      s1          <= RST_FIRST_ROT_SIN;
      c2          <= RST_SECOND_ROT_COS;
      s2          <= RST_SECOND_ROT_SIN;
      sine_tab[0] <= RST_SINE_HALF;
      sine_tab[1] <= RST_SINE_ONE_HALF;
      sine_tab[2] <= RST_SINE_TWO_HALF;
      sine_tab[3] <= RST_SINE_THREE_HALF;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FIRST_ROT_COS:        c1          <= cfg_data;
        REG_FIRST_ROT_SIN:        s1          <= cfg_data;
        REG_SECOND_ROT_COS:       c2          <= cfg_data;
        REG_SECOND_ROT_SIN:       s2          <= cfg_data;
        REG_ZONE_SINE_HALF:       sine_tab[0] <= cfg_data[SINE_W-1:0];
        REG_ZONE_SINE_ONE_HALF:   sine_tab[1] <= cfg_data[SINE_W-1:0];
        REG_ZONE_SINE_TWO_HALF:   sine_tab[2] <= cfg_data[SINE_W-1:0];
        REG_ZONE_SINE_THREE_HALF: sine_tab[3] <= cfg_data[SINE_W-1:0];
        default: ;
      endcase
    end
  end

  // Zones 4..7 lie on the positive side of centre; for zones 0..3 the
  // mirrored entry is found by inverting the low two index bits.
  function automatic logic signed [SSINE_W-1:0] zone_sine(input logic [ZONE_W-1:0] idx,
      input logic [SINE_W-1:0] t0, input logic [SINE_W-1:0] t1,
      input logic [SINE_W-1:0] t2, input logic [SINE_W-1:0] t3);
    logic [1:0]        sel;
    logic [SINE_W-1:0] mag;
    sel = idx[ZONE_W-1] ? idx[1:0] : ~idx[1:0];
    unique case (sel)
      2'd0:    mag = t0;
      2'd1:    mag = t1;
      2'd2:    mag = t2;
      default: mag = t3;
    endcase
    if (idx[ZONE_W-1]) begin
      zone_sine = $signed({1'b0, mag});
    end else begin
      zone_sine = -$signed({1'b0, mag});
    end
  endfunction

  // Stage enables: a stage loads when it is empty or its contents move on.
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;

  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Stage 1: project onto the sensor axes.
  logic signed [SSINE_W-1:0] sine_col, sine_row;
  logic signed [DIST_W:0]    dist_s;
  logic signed [MUL1_W-1:0]  xs_full, ys_full;
  logic signed [XS_W-1:0]    xs1, ys1;
  logic signed [DIST_W:0]    d1;

  assign sine_col = zone_sine(zone_col, sine_tab[0], sine_tab[1], sine_tab[2], sine_tab[3]);
  assign sine_row = zone_sine(zone_row, sine_tab[0], sine_tab[1], sine_tab[2], sine_tab[3]);
  assign dist_s   = $signed({1'b0, range_mm});
  assign xs_full  = dist_s * sine_col;
  assign ys_full  = dist_s * sine_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      xs1 <= xs_full[XS_W-1:0];
      ys1 <= ys_full[XS_W-1:0];
      d1  <= dist_s;
    end
  end

  // Stage 2: products of the first rotation. zs is d shifted up by the
  // fraction bits, so the shift is applied after the multiply.
  logic signed [XS_W-1:0] xs2;
  logic signed [P1_W-1:0] p_c1ys, p_s1ys;
  logic signed [CD_W-1:0] p_c1d, p_s1d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      xs2    <= xs1;
      p_c1ys <= c1 * ys1;
      p_s1ys <= s1 * ys1;
      p_c1d  <= c1 * d1;
      p_s1d  <= s1 * d1;
    end
  end

  // Stage 3: sums of the first rotation; zr is rounded half up to F bits.
  logic signed [ROT1_W-1:0] yr_sum, zr_sum, zr_shift;
  logic signed [ROT1_W-1:0] half1;
  logic signed [XS_W-1:0]   xs3;
  logic signed [ROT1_W-1:0] yr3;
  logic signed [ZR_W-1:0]   zr3;

  assign half1    = ROT1_W'(1) <<< (COEF_FRAC_BITS - 1);
  assign yr_sum   = ROT1_W'(p_c1ys) + (ROT1_W'(p_s1d) <<< COEF_FRAC_BITS);
  assign zr_sum   = (ROT1_W'(p_c1d) <<< COEF_FRAC_BITS) - ROT1_W'(p_s1ys) + half1;
  assign zr_shift = zr_sum >>> COEF_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      xs3 <= xs2;
      yr3 <= yr_sum;
      zr3 <= zr_shift[ZR_W-1:0];
    end
  end

  // Stage 4: products of the second rotation; y is finished here.
  logic signed [P1_W-1:0]  p_c2xs, p_s2xs;
  logic signed [P2_W-1:0]  p_c2zr, p_s2zr;
  logic signed [OUT_W-1:0] oy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      p_c2xs <= c2 * xs3;
      p_s2xs <= s2 * xs3;
      p_c2zr <= c2 * zr3;
      p_s2zr <= s2 * zr3;
      oy4    <= round_sat(WIDE_W'(yr3));
    end
  end

  // Stage 5: sums of the second rotation, rounding and saturation into the
  // output register.
  logic signed [WIDE_W-1:0] x_sum, z_sum;

  assign x_sum = WIDE_W'(p_c2xs) + WIDE_W'(p_s2zr);
  assign z_sum = WIDE_W'(p_c2zr) - WIDE_W'(p_s2xs);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en5) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      out_x <= round_sat(x_sum);
      out_y <= oy4;
      out_z <= round_sat(z_sum);
    end
  end

endmodule

/* design/dptp_checker.sv */
// Port-level checker for the tilted-point pipeline, bound to its top level.
// Depends on dptp_pkg for field widths and the pipeline depth.
module dptp_checker
  import dptp_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] out_x,
  input logic signed [OUT_W-1:0] out_y,
  input logic signed [OUT_W-1:0] out_z
);

  // Number of zones taken in whose points have not yet been handed on.
  logic [CNT_W-1:0] inflight;
  logic             in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(in_xfer) - CNT_W'(out_xfer);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z))
    else $error("stalled result changed or was dropped");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input refused while the output stage is empty");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("result offered with no zone in flight");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(PIPE_DEPTH))
    else $error("more zones held than the pipeline has stages");

endmodule

bind depth_pixel_to_tilted_point dptp_checker u_dptp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z)
);

/* sim/depth_pixel_to_tilted_point_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for depth_pixel_to_tilted_point: predicts every point
// from a shadow of the coefficient registers and checks each output transfer.
// Depends on dptp_pkg and the depth_pixel_to_tilted_point RTL only.
module depth_pixel_to_tilted_point_tb;
  import dptp_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 48;
  localparam int NUM_REGS    = 8;

  typedef struct packed {
    logic [ZONE_W-1:0] col;
    logic [ZONE_W-1:0] row;
    logic [DIST_W-1:0] range_mm;
  } zone_t;

  typedef struct packed {
    zone_t                   zone;
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data    = '0;
  logic                    in_valid    = 1'b0;
  logic                    in_ready;
  logic [ZONE_W-1:0]       zone_col    = '0;
  logic [ZONE_W-1:0]       zone_row    = '0;
  logic [DIST_W-1:0]       range_mm    = '0;
  logic                    out_valid;
  logic                    out_ready   = 1'b0;
  logic signed [OUT_W-1:0] out_x;
  logic signed [OUT_W-1:0] out_y;
  logic signed [OUT_W-1:0] out_z;

  // Shadow of the coefficient registers as the block should hold them.
  logic [CFG_DATA_W-1:0] coef_regs [NUM_REGS];

  zone_t  zone_queue[$];
  point_t predicted_points[$];

  int zones_queued    = 0;
  int zones_accepted  = 0;
  int points_checked  = 0;
  int failures        = 0;
  int settings_used   = 1;
  int idle_pct        = 15;
  int stall_cycles    = 0;
  int hold_left       = 0;
  bit hold_done       = 1'b0;

  depth_pixel_to_tilted_point uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .zone_col    (zone_col),
    .zone_row    (zone_row),
    .range_mm    (range_mm),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Signed sine of a zone index; indices 0..3 lie left of centre and are negative.
  function automatic longint zone_sine(input logic [ZONE_W-1:0] idx);
    logic [CFG_IDX_W-1:0] sel;
    longint               mag;
    sel = idx[2] ? REG_ZONE_SINE_HALF + idx[1:0] : REG_ZONE_SINE_THREE_HALF - idx[1:0];
    mag = longint'(coef_regs[sel][SINE_W-1:0]);
    return idx[2] ? mag : -mag;
  endfunction

  function automatic longint round_half_up(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_mm(input longint v);
    if (v > longint'(OUT_MAX)) return OUT_MAX;
    if (v < longint'(OUT_MIN)) return OUT_MIN;
    return v[OUT_W-1:0];
  endfunction

  function automatic point_t tilt_point(input zone_t zn);
    point_t p;
    longint d, c1, s1, c2, s2, xs, ys, zs, yr2, zr2, zr, x2, z2;
    d   = longint'(zn.range_mm);
    c1  = longint'($signed(coef_regs[REG_FIRST_ROT_COS]));
    s1  = longint'($signed(coef_regs[REG_FIRST_ROT_SIN]));
    c2  = longint'($signed(coef_regs[REG_SECOND_ROT_COS]));
    s2  = longint'($signed(coef_regs[REG_SECOND_ROT_SIN]));
    xs  = d * zone_sine(zn.col);
    ys  = d * zone_sine(zn.row);
    zs  = d <<< COEF_FRAC_BITS;
    yr2 = c1 * ys + s1 * zs;
    zr2 = c1 * zs - s1 * ys;
    // The intermediate depth is rounded back to single precision first.
    zr  = round_half_up(zr2, COEF_FRAC_BITS);
    x2  = c2 * xs + s2 * zr;
    z2  = c2 * zr - s2 * xs;
    p.zone = zn;
    p.x    = clamp_mm(round_half_up(x2, 2 * COEF_FRAC_BITS));
    p.y    = clamp_mm(round_half_up(yr2, 2 * COEF_FRAC_BITS));
    p.z    = clamp_mm(round_half_up(z2, 2 * COEF_FRAC_BITS));
    return p;
  endfunction

  // Sender: one transfer per handshake, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_points.push_back(tilt_point('{zone_col, zone_row, range_mm}));
        zones_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (zone_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          zone_t zn;
          zn = zone_queue.pop_front();
          zone_col    <= zn.col;
          zone_row    <= zn.row;
          range_mm    <= zn.range_mm;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Holds the receiver off once for a long stretch while zones are still
  // waiting, so that the pipeline fills and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && points_checked >= 300 && zone_queue.size() > 20) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end
  end

  // Receiver: checks each output transfer and stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_points.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected point x=%0d y=%0d z=%0d", out_x, out_y, out_z);
        end else begin
          point_t exp_pt;
          exp_pt = predicted_points.pop_front();
          if (out_x !== exp_pt.x || out_y !== exp_pt.y || out_z !== exp_pt.z) begin
            failures++;
            if (failures <= 10)
              $display({"mismatch col %0d row %0d range %0d: ",
                        "expected (%0d,%0d,%0d) got (%0d,%0d,%0d)"},
                       exp_pt.zone.col, exp_pt.zone.row, exp_pt.zone.range_mm,
                       exp_pt.x, exp_pt.y, exp_pt.z, out_x, out_y, out_z);
          end
        end
        points_checked++;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("depth_pixel_to_tilted_point_tb: FAIL");
    $finish;
  end

  task automatic queue_zone(input int col, input int row, input int range_val);
    zone_queue.push_back('{col[ZONE_W-1:0], row[ZONE_W-1:0], range_val[DIST_W-1:0]});
    zones_queued++;
  endtask

  task automatic queue_random(input int n);
    int sel;
    int range_val;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 70)
        range_val = $urandom_range(65535);
      else if (sel < 85)
        range_val = $urandom_range(255);
      else
        range_val = $urandom_range(65535, 65280);
      queue_zone($urandom_range(7), $urandom_range(7), range_val);
    end
  endtask

  // Returns once every queued zone has been transferred and every point checked.
  task automatic wait_drained();
    while (zones_accepted != zones_queued || predicted_points.size() != 0)
      @(posedge clk);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  task automatic load_regs(input logic [CFG_DATA_W-1:0] c1, s1, c2, s2, h0, h1, h2, h3);
    logic [CFG_DATA_W-1:0] vals [NUM_REGS];
    vals[REG_FIRST_ROT_COS]        = c1;
    vals[REG_FIRST_ROT_SIN]        = s1;
    vals[REG_SECOND_ROT_COS]       = c2;
    vals[REG_SECOND_ROT_SIN]       = s2;
    vals[REG_ZONE_SINE_HALF]       = h0;
    vals[REG_ZONE_SINE_ONE_HALF]   = h1;
    vals[REG_ZONE_SINE_TWO_HALF]   = h2;
    vals[REG_ZONE_SINE_THREE_HALF] = h3;
    wait_drained();
    for (int i = 0; i < NUM_REGS; i++) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      coef_regs[i] = vals[i];
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  initial begin
    coef_regs[REG_FIRST_ROT_COS]        = CFG_DATA_W'(RST_FIRST_ROT_COS);
    coef_regs[REG_FIRST_ROT_SIN]        = CFG_DATA_W'(RST_FIRST_ROT_SIN);
    coef_regs[REG_SECOND_ROT_COS]       = CFG_DATA_W'(RST_SECOND_ROT_COS);
    coef_regs[REG_SECOND_ROT_SIN]       = CFG_DATA_W'(RST_SECOND_ROT_SIN);
    coef_regs[REG_ZONE_SINE_HALF]       = CFG_DATA_W'(RST_SINE_HALF);
    coef_regs[REG_ZONE_SINE_ONE_HALF]   = CFG_DATA_W'(RST_SINE_ONE_HALF);
    coef_regs[REG_ZONE_SINE_TWO_HALF]   = CFG_DATA_W'(RST_SINE_TWO_HALF);
    coef_regs[REG_ZONE_SINE_THREE_HALF] = CFG_DATA_W'(RST_SINE_THREE_HALF);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: every zone index at full range, zero and unit distance,
    // exact half-LSB ties on both sides of centre, alternating bit patterns.
    for (int i = 0; i < 8; i++) queue_zone(i, 7 - i, 65535);
    queue_zone(0, 0, 0);
    queue_zone(7, 7, 1);
    queue_zone(4, 4, 4096);
    queue_zone(3, 3, 4096);
    queue_zone(2, 5, 16'h5555);
    queue_zone(5, 2, 16'hAAAA);
    queue_random(120);

    // Upper bounds of every register.
    load_regs(16'd16384, 16'd16384, 16'd16384, 16'd16384,
              16'd16384, 16'd16384, 16'd16384, 16'd16384);
    queue_random(100);

    // Lower bounds, run back to back with no gaps on either side.
    load_regs(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
              16'd0, 16'd0, 16'd0, 16'd0);
    idle_pct = 0;
    queue_random(120);
    wait_drained();
    idle_pct = 15;

    // Extreme bit patterns; the top bit of a sine write must be dropped.
    // Large coefficients drive the full-range zones into saturation.
    load_regs(16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
              16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
    queue_zone(7, 7, 65535);
    queue_zone(0, 0, 65535);
    queue_zone(7, 0, 65535);
    queue_zone(0, 7, 65535);
    queue_zone(5, 6, 0);
    queue_zone(1, 2, 1);
    queue_random(100);

    load_regs(CFG_DATA_W'($urandom_range(65535)), CFG_DATA_W'($urandom_range(65535)),
              CFG_DATA_W'($urandom_range(65535)), CFG_DATA_W'($urandom_range(65535)),
              CFG_DATA_W'($urandom_range(65535)), CFG_DATA_W'($urandom_range(65535)),
              CFG_DATA_W'($urandom_range(65535)), CFG_DATA_W'($urandom_range(65535)));
    queue_random(100);

    // A plausible mounting tilt with a near-default angle table.
    load_regs(16'd16200, -16'sd2400, 16'd15900, 16'd3960,
              16'd920, 16'd2740, 16'd4540, 16'd6275);
    queue_random(130);

    wait_drained();
    $display("Checked %0d points from %0d zones over %0d register settings,",
             points_checked, zones_accepted, settings_used);
    $display("including a %0d-cycle output stall; %0d failures.", HOLD_CYCLES, failures);
    if (failures == 0) begin
      $display("depth_pixel_to_tilted_point_tb: PASS");
    end else begin
      $display("depth_pixel_to_tilted_point_tb: FAIL");
    end
    $finish;
  end

endmodule
